>>> hdl/landing_stability_detector_macros.svh
// Assertion helpers used by the checker file.
`ifndef LANDING_STABILITY_DETECTOR_MACROS_SVH
`define LANDING_STABILITY_DETECTOR_MACROS_SVH

// Clocked assertion with an explicit clock and reset.
`define LSD_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion on the block's own clock and reset.
`define LSD_ASSERT(lbl, prop, msg) \
   `LSD_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

>>> hdl/lsd_pkg.sv
package lsd_pkg;

   localparam int WINDOW = 8;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SWP_W  = $clog2(WINDOW);

   localparam int ALT_W  = 32;
   localparam int TIME_W = 32;

   localparam int REQ_BITS   = 97;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_BITS   = 74;
   localparam int RSP_DATA_W = 80;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_DEPLOY_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PYRO_FIRE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_GAP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STABLE_RNG  = 2'd3;

   localparam logic [15:0] PYRO_FIRE_RESET  = 16'd1000;
   localparam logic [15:0] MAX_GAP_RESET    = 16'd1000;
   localparam logic [30:0] STABLE_RNG_RESET = 31'd512;

   localparam logic MODE_ENTER = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ENABLE  = 2'd1;
   localparam logic [1:0] ACT_DISABLE = 2'd2;

   // First field sits in the highest bits, so members are listed from the top down.
   typedef struct packed {
      logic signed [ALT_W-1:0] sample_altitude;
      logic [TIME_W-1:0]       baro_time_ms;
      logic                    sample_ok;
      logic [TIME_W-1:0]       now_ms;
   } req_type;

   typedef struct packed {
      logic                    go_ground;
      logic signed [ALT_W-1:0] decision_altitude;
      logic [TIME_W-1:0]       decision_time_ms;
      logic [3:0]              window_count;
      logic                    decision_accept;
      logic                    decision_valid;
      logic                    main_complete;
      logic [1:0]              main_action;
   } rsp_type;

   typedef struct packed {
      logic en;
      logic first;
   } sweep_ctl_type;

endpackage

>>> hdl/landing_stability_detector.sv
// After a transaction is accepted, its result goes to the output register; when the sample
// fills the window, the altitudes first rotate once through the cell chain past a single
// min/max unit, one cell per cycle, and the range is then checked.
// No new transaction is taken until the previous result has been loaded for output.
// Reset is synchronous and clears control state and loads register defaults; the window
// cells are not cleared.
module landing_stability_detector
   import lsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms, sample_ok, baro_time_ms, sample_altitude
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // main_action, main_complete, decision_valid, decision_accept, window_count,
   // decision_time_ms, decision_altitude, go_ground
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SWEEP  = 2'd1;
   localparam logic [1:0] S_RANGE  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [TIME_W-1:0] deploy_ff;
   logic [15:0]       pyro_ff;
   logic [15:0]       gap_ff;
   logic [30:0]       range_ff;
   logic              main_off_ff;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [TIME_W-1:0] last_ff;
   logic [SWP_W-1:0]  swp_cnt_ff;
   logic              rsp_valid_ff;
   rsp_type           pend_ff, pend_in;
   rsp_type           out_ff;

   req_type           req;
   logic              req_fire;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] gap;
   logic              fire_off;
   logic              take;
   logic              gap_clear;
   logic [CNT_W-1:0]  base_fill;
   logic              sweep_last;
   logic              out_load;
   logic [ALT_W:0]    spread;
   logic              stable;
   sweep_ctl_type     sweep_ctl;
   logic              shift_en;

   logic signed [ALT_W-1:0] tap [WINDOW];
   logic signed [ALT_W-1:0] head_in;
   logic signed [ALT_W-1:0] lo;
   logic signed [ALT_W-1:0] hi;

   assign req        = req_type'(req_tdata[REQ_BITS-1:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      elapsed   = req.now_ms - deploy_ff;
      gap       = req.baro_time_ms - last_ff;
      fire_off  = (req_tuser == MODE_STEP) && !main_off_ff && (elapsed >= {16'd0, pyro_ff});
      take      = (req_tuser == MODE_STEP) && (main_off_ff || fire_off) && req.sample_ok
                  && (req.baro_time_ms != '0) && (req.baro_time_ms != last_ff);
      gap_clear = (last_ff != '0) && (gap > {16'd0, gap_ff});
      base_fill = gap_clear ? '0 : fill_ff;
      fill_in   = (base_fill < CNT_W'(WINDOW)) ? base_fill + CNT_W'(1) : base_fill;
   end

   assign sweep_last = (swp_cnt_ff == SWP_W'(WINDOW - 1));
   assign out_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (take && fill_in == CNT_W'(WINDOW)) ? S_SWEEP : S_FINISH;
            end
         end
         S_SWEEP: begin
            if (sweep_last) begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         deploy_ff    <= '0;
         pyro_ff      <= PYRO_FIRE_RESET;
         gap_ff       <= MAX_GAP_RESET;
         range_ff     <= STABLE_RNG_RESET;
         main_off_ff  <= 1'b0;
         fill_ff      <= '0;
         last_ff      <= '0;
         swp_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_DEPLOY_TIME: deploy_ff <= csr_wdata;
               REG_PYRO_FIRE:   pyro_ff   <= csr_wdata[15:0];
               REG_MAX_GAP:     gap_ff    <= csr_wdata[15:0];
               REG_STABLE_RNG:  range_ff  <= csr_wdata[30:0];
            endcase
         end
         if (req_fire) begin
            if (req_tuser == MODE_ENTER) begin
               main_off_ff <= 1'b0;
               fill_ff     <= '0;
               last_ff     <= '0;
            end else begin
               if (fire_off) begin
                  main_off_ff <= 1'b1;
               end
               if (take) begin
                  fill_ff <= fill_in;
                  last_ff <= req.baro_time_ms;
               end
            end
         end
         if (req_fire) begin
            swp_cnt_ff <= '0;
         end else if (state_ff == S_SWEEP) begin
            swp_cnt_ff <= swp_cnt_ff + SWP_W'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (req_fire) begin
         pend_in = '0;
         if (req_tuser == MODE_ENTER) begin
            pend_in.main_action = ACT_ENABLE;
         end else begin
            pend_in.main_action   = fire_off ? ACT_DISABLE : ACT_NONE;
            pend_in.main_complete = fire_off;
            pend_in.window_count  = 4'(take ? fill_in : fill_ff);
            if (take) begin
               pend_in.decision_valid    = 1'b1;
               pend_in.decision_time_ms  = req.baro_time_ms;
               pend_in.decision_altitude = req.sample_altitude;
            end
         end
      end else if (state_ff == S_RANGE) begin
         pend_in.decision_accept = stable;
         pend_in.go_ground       = stable;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (out_load) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_BITS)'(0), out_ff};

   assign shift_en  = (req_fire && take) || (state_ff == S_SWEEP);
   assign head_in   = (state_ff == S_SWEEP) ? tap[WINDOW-1] : req.sample_altitude;
   assign sweep_ctl = '{en: (state_ff == S_SWEEP), first: (swp_cnt_ff == '0)};

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         lsd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (head_in),
            .q        (tap[i])
         );
      end else begin : g_body
         lsd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (tap[i-1]),
            .q        (tap[i])
         );
      end
   end

   lsd_minmax u_minmax (
      .clock (clock),
      .ctl   (sweep_ctl),
      .value (tap[WINDOW-1]),
      .lo    (lo),
      .hi    (hi)
   );

   assign spread = {hi[ALT_W-1], hi} - {lo[ALT_W-1], lo};
   assign stable = (spread <= {2'b00, range_ff});

endmodule

>>> hdl/lsd_cell.sv
module lsd_cell
   import lsd_pkg::*;
(
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic signed [ALT_W-1:0] d_in,
   output logic signed [ALT_W-1:0] q
);

   logic signed [ALT_W-1:0] alt_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         alt_ff <= d_in;
      end
   end

   assign q = alt_ff;

endmodule

>>> hdl/lsd_minmax.sv
module lsd_minmax
   import lsd_pkg::*;
(
   input  logic                    clock,
   input  sweep_ctl_type           ctl,
   input  logic signed [ALT_W-1:0] value,
   output logic signed [ALT_W-1:0] lo,
   output logic signed [ALT_W-1:0] hi
);

   logic signed [ALT_W-1:0] lo_ff;
   logic signed [ALT_W-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (ctl.first || value < lo_ff) begin
            lo_ff <= value;
         end
         if (ctl.first || value > hi_ff) begin
            hi_ff <= value;
         end
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

>>> hdl/lsd_checker.sv
`include "landing_stability_detector_macros.svh"

module lsd_checker
   import lsd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type rsp;

   assign rsp = rsp_type'(rsp_tdata[RSP_BITS-1:0]);

   `LSD_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "Stalled result changed or was dropped.")
   `LSD_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "A second transaction was taken while one is in progress.")
   `LSD_ASSERT(a_accept_full, rsp_tvalid && rsp.decision_accept |-> rsp.decision_valid && rsp.go_ground && rsp.window_count == 4'(WINDOW), "Landing accepted without a full window decision.")
   `LSD_ASSERT(a_enter_clears, rsp_tvalid && rsp.main_action == ACT_ENABLE |-> rsp.window_count == 4'd0 && !rsp.decision_valid && !rsp.main_complete, "Enter result does not show a cleared window.")

endmodule

bind landing_stability_detector lsd_checker u_lsd_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lsd_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = MODE_ENTER;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_DEPLOY_TIME;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   landing_stability_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   typedef struct {
      logic    chk;
      rsp_type want;
   } typed_rsp_type;

   typedef struct {
      logic    mode;
      req_type req;
      logic    chk;
      rsp_type want;
   } dir_row_type;

   // Register copies and detector state for the landing predictor.
   logic [31:0]             cfg_deploy_ms = 32'd0;
   logic [15:0]             cfg_pyro_ms   = PYRO_FIRE_RESET;
   logic [15:0]             cfg_gap_ms    = MAX_GAP_RESET;
   logic [30:0]             cfg_range     = STABLE_RNG_RESET;
   logic                    main_is_off   = 1'b0;
   logic [SWP_W-1:0]        win_pos       = '0;
   logic [3:0]              win_fill      = 4'd0;
   logic [31:0]             last_sample_ms = 32'd0;
   logic signed [ALT_W-1:0] win_alt [WINDOW];

   rsp_type       predicted_rsp [$];
   typed_rsp_type typed_rsp [$];
   dir_row_type   dir_tab [$];

   int  err_count      = 0;
   int  accepted_count = 0;
   int  decision_count = 0;
   int  landing_count  = 0;
   int  disable_count  = 0;
   bit  sender_idles   = 1'b1;
   bit  rsp_idles      = 1'b1;
   bit  hold_rsp       = 1'b0;
   int  stall_left     = 0;
   int  rsp_roll;
   rsp_type       pred_rsp;
   rsp_type       got_rsp;
   rsp_type       want_rsp;
   typed_rsp_type typed_entry;

   function automatic rsp_type landing_predict(input logic mode, input req_type r);
      rsp_type     o;
      logic [31:0] elapsed;
      longint      lo;
      longint      hi;
      o = '0;
      if (mode == MODE_ENTER) begin
         main_is_off = 1'b0;
         win_pos = '0;
         win_fill = 4'd0;
         last_sample_ms = 32'd0;
         o.main_action = ACT_ENABLE;
      end else begin
         elapsed = r.now_ms - cfg_deploy_ms;
         if (!main_is_off && elapsed >= {16'd0, cfg_pyro_ms}) begin
            o.main_action = ACT_DISABLE;
            o.main_complete = 1'b1;
            main_is_off = 1'b1;
         end
         if (main_is_off && r.sample_ok && r.baro_time_ms != 32'd0
             && r.baro_time_ms != last_sample_ms) begin
            if (last_sample_ms != 32'd0
                && (r.baro_time_ms - last_sample_ms) > {16'd0, cfg_gap_ms}) begin
               win_pos = '0;
               win_fill = 4'd0;
            end
            last_sample_ms = r.baro_time_ms;
            win_alt[win_pos] = r.sample_altitude;
            win_pos = win_pos + SWP_W'(1);
            if (win_fill < 4'(WINDOW))
               win_fill = win_fill + 4'd1;
            o.decision_valid = 1'b1;
            if (win_fill == 4'(WINDOW)) begin
               lo = win_alt[0];
               hi = win_alt[0];
               for (int i = 1; i < WINDOW; i++) begin
                  if (win_alt[i] < lo)
                     lo = win_alt[i];
                  if (win_alt[i] > hi)
                     hi = win_alt[i];
               end
               o.decision_accept = (hi - lo) <= longint'({1'b0, cfg_range});
            end
            o.decision_time_ms = r.baro_time_ms;
            o.decision_altitude = r.sample_altitude;
            o.go_ground = o.decision_accept;
         end
      end
      o.window_count = win_fill;
      return o;
   endfunction

   function automatic req_type mk_req(input logic [31:0] now, input logic ok,
                                      input logic [31:0] stime, input logic [31:0] alt);
      req_type r;
      r.now_ms = now;
      r.sample_ok = ok;
      r.baro_time_ms = stime;
      r.sample_altitude = alt;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [1:0] act, input logic comp, input logic dv,
                                      input logic acc, input logic [3:0] cnt,
                                      input logic [31:0] t, input logic [31:0] alt);
      rsp_type o;
      o.main_action = act;
      o.main_complete = comp;
      o.decision_valid = dv;
      o.decision_accept = acc;
      o.window_count = cnt;
      o.decision_time_ms = t;
      o.decision_altitude = alt;
      o.go_ground = acc;
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!sender_idles)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_row(input logic mode, input logic [31:0] now, input logic ok,
                          input logic [31:0] stime, input logic [31:0] alt,
                          input logic chk, input rsp_type want);
      dir_row_type row;
      row.mode = mode;
      row.req = mk_req(now, ok, stime, alt);
      row.chk = chk;
      row.want = want;
      dir_tab.push_back(row);
   endtask

   task automatic send(input logic mode, input req_type r, input logic chk,
                       input rsp_type want);
      int            gap;
      typed_rsp_type te;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      te.chk = chk;
      te.want = want;
      typed_rsp.push_back(te);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= REQ_DATA_W'(r);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      while (predicted_rsp.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(negedge clock);
   endtask

   task automatic set_regs(input logic [31:0] d, input logic [15:0] p,
                           input logic [15:0] g, input logic [30:0] s);
      csr_we <= 1'b1;
      csr_index <= REG_DEPLOY_TIME;
      csr_wdata <= d;
      @(negedge clock);
      csr_index <= REG_PYRO_FIRE;
      csr_wdata <= CSR_DATA_W'(p);
      @(negedge clock);
      csr_index <= REG_MAX_GAP;
      csr_wdata <= CSR_DATA_W'(g);
      @(negedge clock);
      csr_index <= REG_STABLE_RNG;
      csr_wdata <= CSR_DATA_W'(s);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_deploy_ms = d;
      cfg_pyro_ms = p;
      cfg_gap_ms = g;
      cfg_range = s;
   endtask

   // Mostly well-formed descent traffic: steady time steps and altitudes scattered around
   // a base by about the stable range, mixed with rejected samples, gaps and re-entries.
   task automatic run_phase(input logic [31:0] d, input logic [15:0] p, input logic [15:0] g,
                            input logic [30:0] s, input int n, input bit sidle,
                            input bit ridle, input bit hold);
      logic [31:0] g_now;
      logic [31:0] g_stime;
      logic [31:0] g_base;
      int          now_max;
      int          gap_hint;
      int          amp;
      int          roll;
      settle();
      set_regs(d, p, g, s);
      sender_idles = sidle;
      rsp_idles = ridle;
      if (hold)
         hold_rsp = 1'b1;
      g_now = d + $urandom_range(0, 50);
      g_stime = ($urandom_range(0, 3) == 0) ? 32'hFFFFFF00 + $urandom_range(0, 200) : $urandom;
      g_base = $urandom;
      now_max = p / 8 + 50;
      gap_hint = (g == 16'd0) ? 1 : g;
      amp = 0;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (i == 0 || roll < 3) begin
            g_base = $urandom;
            amp = (s > 31'd1048576) ? 1048576 : int'(s);
            if ($urandom_range(0, 3) == 0)
               amp = amp + amp / 2 + 1;
         end
         g_now = g_now + $urandom_range(1, now_max);
         if (i == 0 || (roll >= 88 && roll < 91)) begin
            send(MODE_ENTER, mk_req(g_now, 1'b1, g_stime, g_base), 1'b0, '0);
         end else if (roll < 78) begin
            g_stime = g_stime + $urandom_range(1, gap_hint);
            if (g_stime == 32'd0)
               g_stime = 32'd1;
            send(MODE_STEP, mk_req(g_now, 1'b1, g_stime, g_base + $urandom_range(0, amp)),
                 1'b0, '0);
         end else if (roll < 82) begin
            send(MODE_STEP, mk_req(g_now, 1'b0, $urandom, $urandom), 1'b0, '0);
         end else if (roll < 84) begin
            send(MODE_STEP, mk_req(g_now, 1'b1, 32'd0, $urandom), 1'b0, '0);
         end else if (roll < 86) begin
            send(MODE_STEP, mk_req(g_now, 1'b1, g_stime, $urandom), 1'b0, '0);
         end else if (roll < 88) begin
            g_stime = g_stime + g + 1 + $urandom_range(0, 100000);
            if (g_stime == 32'd0)
               g_stime = 32'd1;
            send(MODE_STEP, mk_req(g_now, 1'b1, g_stime, g_base + $urandom_range(0, amp)),
                 1'b0, '0);
         end else begin
            send($urandom_range(0, 1), mk_req($urandom, $urandom_range(0, 1), $urandom,
                 $urandom), 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_rsp) begin
         hold_rsp = 1'b0;
         stall_left = 400;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!rsp_idles) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 65) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = (rsp_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pred_rsp = landing_predict(req_tuser, req_type'(req_tdata[REQ_BITS-1:0]));
            typed_entry = typed_rsp.pop_front();
            predicted_rsp.push_back(typed_entry.chk ? typed_entry.want : pred_rsp);
            accepted_count++;
            decision_count += pred_rsp.decision_valid;
            landing_count += pred_rsp.decision_accept;
            disable_count += pred_rsp.main_complete;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
            if (predicted_rsp.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("%0t: result transaction with nothing expected: %h", $realtime,
                           got_rsp);
            end else begin
               want_rsp = predicted_rsp.pop_front();
               if (got_rsp.main_action !== want_rsp.main_action
                   || got_rsp.main_complete !== want_rsp.main_complete
                   || got_rsp.decision_valid !== want_rsp.decision_valid
                   || got_rsp.decision_accept !== want_rsp.decision_accept
                   || got_rsp.window_count !== want_rsp.window_count
                   || got_rsp.decision_time_ms !== want_rsp.decision_time_ms
                   || got_rsp.decision_altitude !== want_rsp.decision_altitude
                   || got_rsp.go_ground !== want_rsp.go_ground) begin
                  err_count++;
                  if (err_count <= 10)
                     $display({"%0t: mismatch act/cmp/dv/acc/cnt/time/alt/gnd ",
                               "expected %0d %b %b %b %0d %h %h %b, got %0d %b %b %b %0d %h %h %b"},
                              $realtime, want_rsp.main_action, want_rsp.main_complete,
                              want_rsp.decision_valid, want_rsp.decision_accept,
                              want_rsp.window_count, want_rsp.decision_time_ms,
                              want_rsp.decision_altitude, want_rsp.go_ground,
                              got_rsp.main_action, got_rsp.main_complete,
                              got_rsp.decision_valid, got_rsp.decision_accept,
                              got_rsp.window_count, got_rsp.decision_time_ms,
                              got_rsp.decision_altitude, got_rsp.go_ground);
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_row(MODE_ENTER, 0, 0, 0, 0, 1, mk_rsp(ACT_ENABLE, 0, 0, 0, 0, 0, 0));
      add_row(MODE_STEP, 999, 1, 50, 0, 1, mk_rsp(ACT_NONE, 0, 0, 0, 0, 0, 0));
      add_row(MODE_STEP, 1000, 1, 100, 32'h7FFFFFFF, 1,
              mk_rsp(ACT_DISABLE, 1, 1, 0, 1, 100, 32'h7FFFFFFF));
      add_row(MODE_STEP, 1001, 0, 150, 0, 1, mk_rsp(ACT_NONE, 0, 0, 0, 1, 0, 0));
      add_row(MODE_STEP, 1002, 1, 0, 5, 1, mk_rsp(ACT_NONE, 0, 0, 0, 1, 0, 0));
      add_row(MODE_STEP, 1003, 1, 100, 5, 1, mk_rsp(ACT_NONE, 0, 0, 0, 1, 0, 0));
      add_row(MODE_STEP, 1004, 1, 200, 32'h80000000, 1,
              mk_rsp(ACT_NONE, 0, 1, 0, 2, 200, 32'h80000000));
      for (int i = 0; i < 6; i++)
         add_row(MODE_STEP, 1005 + i, 1, 300 + 100 * i, 256 * i, 0, '0);
      add_row(MODE_STEP, 2000, 1, 5000, 1000, 1, mk_rsp(ACT_NONE, 0, 1, 0, 1, 5000, 1000));
      for (int i = 1; i < 8; i++)
         add_row(MODE_STEP, 2000 + i, 1, 5000 + 100 * i, 1000 + 60 * i, 0, '0);
      add_row(MODE_STEP, 2100, 1, 32'hFFFFFFF0, 32'hFFFFFF00, 0, '0);
      add_row(MODE_STEP, 2101, 1, 32'h00000005, 32'hFFFFFF10, 0, '0);
      add_row(MODE_ENTER, 32'hFFFFFFFF, 1, 6, 0, 1, mk_rsp(ACT_ENABLE, 0, 0, 0, 0, 0, 0));
      add_row(MODE_STEP, 500, 1, 10, 0, 1, mk_rsp(ACT_NONE, 0, 0, 0, 0, 0, 0));
      foreach (dir_tab[i])
         send(dir_tab[i].mode, dir_tab[i].req, dir_tab[i].chk, dir_tab[i].want);
      req_tvalid <= 1'b0;

      run_phase(32'd0, 16'd0, 16'hFFFF, 31'h7FFFFFFF, 100, 1, 1, 0);
      run_phase(32'hFFFFFFFF, 16'hFFFF, 16'd0, 31'd0, 100, 1, 1, 0);
      run_phase($urandom, $urandom_range(0, 2000), $urandom_range(20, 500),
                $urandom_range(0, 4000), 100, 0, 0, 0);
      run_phase($urandom, 16'd300, 16'd1000, 31'd512, 100, 0, 1, 1);
      run_phase(32'hFFFFFF00, 16'd600, 16'd200, 31'd0, 100, 1, 1, 0);
      run_phase($urandom, $urandom, $urandom, $urandom, 100, 1, 1, 0);
      run_phase(32'd0, PYRO_FIRE_RESET, MAX_GAP_RESET, STABLE_RNG_RESET, 100, 1, 1, 0);

      settle();
      if (predicted_rsp.size() != 0) begin
         err_count += predicted_rsp.size();
         $display("%0d expected results never arrived", predicted_rsp.size());
      end
      $display("testbench: %0d transactions in, %0d main-off events, %0d decisions, %0d landings",
               accepted_count, disable_count, decision_count, landing_count);
      $display("testbench: directed table plus 7 register settings, one with a long output stall");
      if (err_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
